// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the core RTL.
// Same-cycle implication under synchronous reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CPD_ASSERT_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication under synchronous reset.
`define CPD_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- rtl/core/cpd_pkg.sv -----
package cpd_pkg;

   localparam int COUNT_BITS_DEF  = 40;
   localparam int MAX_COLUMNS_DEF = 4096;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int CSR_INDEX_BITS = 1;

   localparam logic OP_SAMPLE  = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] REG_TOTAL   = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COLUMNS = 1'b1;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_flags_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ----- rtl/core/cpd_queue.sv -----
`include "assert_macros.svh"

module cpd_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic [WIDTH-1:0]         push_data,
   input  logic                     pop,
   output logic [WIDTH-1:0]         pop_data,
   output cpd_pkg::queue_flags_type flags
);
   import cpd_pkg::*;

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign flags.full  = (count_ff == CNT_BITS'(DEPTH));
   assign flags.empty = (count_ff == '0);
   assign do_push     = push && !flags.full;
   assign do_pop      = pop && !flags.empty;
   assign pop_data    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `CPD_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_BITS'(DEPTH), "queue count above depth")

endmodule

// ----- rtl/core/cpd_front.sv -----
module cpd_front #(
   parameter int SAMPLE_BITS = cpd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic                        req_op,
   input  logic [SAMPLE_BITS-1:0]      req_sample,
   input  logic                        item_pop,
   output logic [2*SAMPLE_BITS+1:0]    item_data,
   output cpd_pkg::queue_flags_type    item_flags
);
   import cpd_pkg::*;

   localparam int MAG_BITS  = SAMPLE_BITS + 1;
   localparam int ITEM_BITS = 2 * SAMPLE_BITS + 2;

   logic [MAG_BITS-1:0]  magnitude;
   logic [ITEM_BITS-1:0] item_packed;

   // magnitude of a two's complement sample, exact for the most negative code
   assign magnitude = req_sample[SAMPLE_BITS-1] ? ({1'b0, ~req_sample} + MAG_BITS'(1))
                                                : {1'b0, req_sample};
   assign item_packed = {req_op, req_sample, magnitude};
   assign req_full    = item_flags.full;

   cpd_queue #(
      .WIDTH (ITEM_BITS),
      .DEPTH (2)
   ) u_item_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (item_packed),
      .pop       (item_pop),
      .pop_data  (item_data),
      .flags     (item_flags)
   );

endmodule

// ----- rtl/core/cpd_divider.sv -----
`include "assert_macros.svh"

module cpd_divider #(
   parameter int COUNT_BITS = cpd_pkg::COUNT_BITS_DEF,
   parameter int DIV_BITS   = 13
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [COUNT_BITS-1:0]     dividend,
   input  logic [DIV_BITS-1:0]       divisor,
   output logic [COUNT_BITS-1:0]     quotient,
   output logic [DIV_BITS-1:0]       remainder,
   output cpd_pkg::div_status_type   status
);
   import cpd_pkg::*;

   localparam int STEP_BITS = $clog2(COUNT_BITS + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_BITS-1:0]  steps_ff, steps_in;
   logic [COUNT_BITS-1:0] work_ff, work_in;
   logic [DIV_BITS-1:0]   rem_ff, rem_in;
   logic [DIV_BITS-1:0]   dvs_ff, dvs_in;
   logic [DIV_BITS:0]     shifted;
   logic [DIV_BITS:0]     diff;
   logic                  fits;

   assign shifted = {rem_ff, work_ff[COUNT_BITS-1]};
   assign fits    = (shifted >= {1'b0, dvs_ff});
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      steps_in = steps_ff;
      work_in  = work_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      if (start) begin
         busy_in  = 1'b1;
         steps_in = STEP_BITS'(COUNT_BITS);
         work_in  = dividend;
         rem_in   = '0;
         dvs_in   = divisor;
      end else if (busy_ff) begin
         work_in  = {work_ff[COUNT_BITS-2:0], fits};
         rem_in   = fits ? diff[DIV_BITS-1:0] : shifted[DIV_BITS-1:0];
         steps_in = steps_ff - STEP_BITS'(1);
         if (steps_ff == STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         steps_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         steps_ff <= steps_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign quotient    = work_ff;
   assign remainder   = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   `CPD_ASSERT_NEXT(a_start_busy, clock, reset, start, busy_ff, "divider idle after start")

endmodule

// ----- rtl/core/cpd_engine.sv -----
`include "assert_macros.svh"

module cpd_engine #(
   parameter int COUNT_BITS  = cpd_pkg::COUNT_BITS_DEF,
   parameter int MAX_COLUMNS = cpd_pkg::MAX_COLUMNS_DEF,
   parameter int SAMPLE_BITS = cpd_pkg::SAMPLE_BITS_DEF,
   parameter int COL_BITS    = $clog2(MAX_COLUMNS + 1),
   parameter int IDX_BITS    = $clog2(MAX_COLUMNS)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [COUNT_BITS-1:0]                 total_samples,
   input  logic [COL_BITS-1:0]                   column_count,
   input  logic [2*SAMPLE_BITS+1:0]              item_data,
   input  cpd_pkg::queue_flags_type              item_flags,
   output logic                                  item_pop,
   output logic                                  out_push,
   output logic [IDX_BITS+SAMPLE_BITS:0]         out_data,
   input  cpd_pkg::queue_flags_type              out_flags
);
   import cpd_pkg::*;

   localparam int MAG_BITS = SAMPLE_BITS + 1;
   localparam logic [COL_BITS-1:0] MAX_COL = COL_BITS'(MAX_COLUMNS);
   localparam logic ST_RUN  = 1'b0;
   localparam logic ST_WAIT = 1'b1;

   logic                   state_ff, state_in;
   logic [COUNT_BITS-1:0]  counter_ff, counter_in;
   logic [COL_BITS-1:0]    column_ff, column_in;
   logic [COUNT_BITS-1:0]  limit_ff, limit_in;
   logic [SAMPLE_BITS-1:0] peak_ff, peak_in;
   logic [MAG_BITS-1:0]    mag_ff, mag_in;
   logic [COUNT_BITS-1:0]  quot_ff, quot_in;
   logic [COL_BITS-1:0]    rem_ff, rem_in;
   logic [COL_BITS-1:0]    frac_ff, frac_in;
   logic [COL_BITS-1:0]    cols_ff, cols_in;

   logic                   in_op;
   logic [SAMPLE_BITS-1:0] in_sample;
   logic [MAG_BITS-1:0]    in_mag;
   logic [COL_BITS-1:0]    cols_sat;
   logic                   active;
   logic                   higher;
   logic [SAMPLE_BITS-1:0] peak_sel;
   logic [MAG_BITS-1:0]    mag_sel;
   logic [COUNT_BITS-1:0]  counter_next;
   logic                   close;
   logic                   last;
   logic [COL_BITS:0]      frac_sum;
   logic [COL_BITS:0]      frac_wrapped;
   logic                   frac_carry;
   logic                   div_start;
   logic [COUNT_BITS-1:0]  div_quot;
   logic [COL_BITS-1:0]    div_rem;
   div_status_type         div_status;

   assign {in_op, in_sample, in_mag} = item_data;

   assign cols_sat     = (column_count > MAX_COL) ? MAX_COL : column_count;
   assign active       = (column_ff < cols_ff);
   assign higher       = (in_mag > mag_ff);
   assign peak_sel     = higher ? in_sample : peak_ff;
   assign mag_sel      = higher ? in_mag : mag_ff;
   assign counter_next = (&counter_ff) ? counter_ff : counter_ff + COUNT_BITS'(1);
   assign close        = active && (counter_next >= limit_ff);
   assign last         = (({1'b0, column_ff} + (COL_BITS+1)'(1)) == {1'b0, cols_ff});
   assign frac_sum     = {1'b0, frac_ff} + {1'b0, rem_ff};
   assign frac_carry   = (cols_ff != '0) && (frac_sum >= {1'b0, cols_ff});
   assign frac_wrapped = frac_sum - {1'b0, cols_ff};
   assign out_data     = {column_ff[IDX_BITS-1:0], peak_sel, last};

   always_comb begin
      state_in   = state_ff;
      counter_in = counter_ff;
      column_in  = column_ff;
      limit_in   = limit_ff;
      peak_in    = peak_ff;
      mag_in     = mag_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      frac_in    = frac_ff;
      cols_in    = cols_ff;
      item_pop   = 1'b0;
      out_push   = 1'b0;
      div_start  = 1'b0;
      unique case (state_ff)
         ST_RUN: begin
            if (!item_flags.empty) begin
               if (in_op == OP_RESTART) begin
                  div_start  = 1'b1;
                  item_pop   = 1'b1;
                  state_in   = ST_WAIT;
                  cols_in    = cols_sat;
                  counter_in = '0;
                  column_in  = '0;
                  peak_in    = '0;
                  mag_in     = '0;
               end else if (!(close && out_flags.full)) begin
                  item_pop = 1'b1;
                  if (active) begin
                     counter_in = counter_next;
                     if (close) begin
                        out_push  = 1'b1;
                        column_in = column_ff + COL_BITS'(1);
                        limit_in  = limit_ff + quot_ff + COUNT_BITS'(frac_carry);
                        frac_in   = frac_carry ? frac_wrapped[COL_BITS-1:0]
                                               : frac_sum[COL_BITS-1:0];
                        peak_in   = '0;
                        mag_in    = '0;
                     end else begin
                        peak_in = peak_sel;
                        mag_in  = mag_sel;
                     end
                  end
               end
            end
         end
         ST_WAIT: begin
            if (div_status.done) begin
               state_in = ST_RUN;
               if (cols_ff == '0) begin
                  quot_in  = '0;
                  rem_in   = '0;
                  frac_in  = '0;
                  limit_in = '0;
               end else begin
                  quot_in  = div_quot;
                  rem_in   = div_rem;
                  frac_in  = div_rem;
                  limit_in = div_quot;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_RUN;
         counter_ff <= '0;
         column_ff  <= '0;
         limit_ff   <= '0;
         peak_ff    <= '0;
         mag_ff     <= '0;
         quot_ff    <= '0;
         rem_ff     <= '0;
         frac_ff    <= '0;
         cols_ff    <= COL_BITS'(1);
      end else begin
         state_ff   <= state_in;
         counter_ff <= counter_in;
         column_ff  <= column_in;
         limit_ff   <= limit_in;
         peak_ff    <= peak_in;
         mag_ff     <= mag_in;
         quot_ff    <= quot_in;
         rem_ff     <= rem_in;
         frac_ff    <= frac_in;
         cols_ff    <= cols_in;
      end
   end

   cpd_divider #(
      .COUNT_BITS (COUNT_BITS),
      .DIV_BITS   (COL_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (total_samples),
      .divisor   (cols_sat),
      .quotient  (div_quot),
      .remainder (div_rem),
      .status    (div_status)
   );

   `CPD_ASSERT_IMPL(a_wait_divider, clock, reset, state_ff == ST_WAIT, div_status.busy || div_status.done, "waiting without divider activity")
   `CPD_ASSERT_IMPL(a_wait_no_pop, clock, reset, state_ff == ST_WAIT, !item_pop, "item taken during restart")
   `CPD_ASSERT_IMPL(a_push_room, clock, reset, out_push, !out_flags.full, "result pushed into full queue")

endmodule

// ----- rtl/core/column_peak_decimator_top.sv -----
// Peak-hold decimator: turns a stream of signed samples into waveform columns.
// Input channel: req_push/req_full with req_op (sample or restart) and req_sample.
// An item is taken at a clock edge with req_push high and req_full low.
// Result channel: rsp_empty/rsp_pop with rsp_column_index, rsp_peak_sample and
// rsp_last_column; the oldest result is shown while rsp_empty is low.
// Configuration: csr_we/csr_index/csr_wdata write total_samples (index 0) and
// column_count (index 1); new values take effect at the next restart item.
// Throughput: one sample item per cycle while no restart is in progress and the
// result queue has room. A restart item occupies the back end while the
// bit-serial divider forms the column step quotient and remainder; up to two
// further items queue meanwhile. A closing sample passes the input queue and
// then the result queue registers before it shows on the result channel.
// Reset: counters, peak and queues clear; the block acts as one column of limit 0
// until a restart, and total_samples resets to 0, column_count to 1.
// A stalled receiver fills the two-entry result queue; the back end then holds
// a closing sample, and the two-entry input queue fills and raises req_full.
module column_peak_decimator_top #(
   parameter int COUNT_BITS  = cpd_pkg::COUNT_BITS_DEF,
   parameter int MAX_COLUMNS = cpd_pkg::MAX_COLUMNS_DEF,
   parameter int SAMPLE_BITS = cpd_pkg::SAMPLE_BITS_DEF,
   parameter int COL_BITS    = $clog2(MAX_COLUMNS + 1),
   parameter int IDX_BITS    = $clog2(MAX_COLUMNS),
   parameter int CSR_BITS    = (COUNT_BITS > COL_BITS) ? COUNT_BITS : COL_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [cpd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [CSR_BITS-1:0]                 csr_wdata,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic                                req_op,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [IDX_BITS-1:0]                 rsp_column_index,
   output logic signed [SAMPLE_BITS-1:0]       rsp_peak_sample,
   output logic                                rsp_last_column
);
   import cpd_pkg::*;

   localparam int ITEM_BITS = 2 * SAMPLE_BITS + 2;
   localparam int RSP_BITS  = IDX_BITS + SAMPLE_BITS + 1;

   logic [COUNT_BITS-1:0] total_ff;
   logic [COL_BITS-1:0]   columns_ff;
   logic [ITEM_BITS-1:0]  item_data;
   queue_flags_type       item_flags;
   logic                  item_pop;
   logic                  out_push;
   logic [RSP_BITS-1:0]   out_data;
   logic [RSP_BITS-1:0]   rsp_data;
   queue_flags_type       out_flags;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff   <= '0;
         columns_ff <= COL_BITS'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            REG_TOTAL:   total_ff   <= csr_wdata[COUNT_BITS-1:0];
            REG_COLUMNS: columns_ff <= csr_wdata[COL_BITS-1:0];
         endcase
      end
   end

   cpd_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_op     (req_op),
      .req_sample (req_sample),
      .item_pop   (item_pop),
      .item_data  (item_data),
      .item_flags (item_flags)
   );

   cpd_engine #(
      .COUNT_BITS  (COUNT_BITS),
      .MAX_COLUMNS (MAX_COLUMNS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .COL_BITS    (COL_BITS),
      .IDX_BITS    (IDX_BITS)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .total_samples (total_ff),
      .column_count  (columns_ff),
      .item_data     (item_data),
      .item_flags    (item_flags),
      .item_pop      (item_pop),
      .out_push      (out_push),
      .out_data      (out_data),
      .out_flags     (out_flags)
   );

   cpd_queue #(
      .WIDTH (RSP_BITS),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .flags     (out_flags)
   );

   assign rsp_empty = out_flags.empty;
   assign {rsp_column_index, rsp_peak_sample, rsp_last_column} = rsp_data;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
   import cpd_pkg::*;

   localparam longint unsigned COUNT_MAX = 64'h0000_00FF_FFFF_FFFF;
   localparam int unsigned MAX_COLS = MAX_COLUMNS_DEF;
   localparam int SETTLE_CYCLES = 200;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASE_ITEMS = 440;
   localparam int SPAN_CAP = 90;
   localparam int WIDE_SPAN = 64;

   typedef struct packed {
      logic [11:0] column_index;
      logic signed [15:0] peak_sample;
      logic last_column;
   } column_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = REG_TOTAL;
   logic [39:0] csr_wdata = '0;
   logic req_push = 1'b0;
   logic req_full;
   logic req_op = OP_SAMPLE;
   logic signed [15:0] req_sample = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic [11:0] rsp_column_index;
   logic signed [15:0] rsp_peak_sample;
   logic rsp_last_column;

   // register copies and decimator state
   longint unsigned cfg_total = 0;
   longint unsigned cfg_columns = 1;
   longint unsigned active_columns = 1;
   longint unsigned step_quot = 0;
   longint unsigned step_rem = 0;
   longint unsigned step_frac = 0;
   longint unsigned samples_seen = 0;
   longint unsigned open_column = 0;
   longint unsigned close_limit = 0;
   logic signed [15:0] held_peak = '0;
   int held_magnitude = 0;

   column_result_type pending_columns[$];
   column_result_type want;
   logic signed [15:0] recent_sample = '0;
   int unsigned push_idle_pct = 0;
   int unsigned pop_stall_pct = 0;
   int fault_count = 0;
   int counted_items = 0;
   int cycle_count = 0;

   column_peak_decimator_top dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_push(req_push),
      .req_full(req_full),
      .req_op(req_op),
      .req_sample(req_sample),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_column_index(rsp_column_index),
      .rsp_peak_sample(rsp_peak_sample),
      .rsp_last_column(rsp_last_column)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("column_peak_decimator_top test failed");
         $finish;
      end
   end

   // returns 1 when the item is a restart or a sample that is not dropped
   function automatic bit advance_decimator(input logic op, input logic signed [15:0] value);
      int magnitude;
      column_result_type closed;
      if (op == OP_RESTART) begin
         active_columns = (cfg_columns > MAX_COLS) ? MAX_COLS : cfg_columns;
         step_quot = (active_columns == 0) ? 0 : cfg_total / active_columns;
         step_rem = (active_columns == 0) ? 0 : cfg_total % active_columns;
         step_frac = step_rem;
         samples_seen = 0;
         open_column = 0;
         close_limit = step_quot;
         held_peak = '0;
         held_magnitude = 0;
         return 1'b1;
      end
      if (open_column >= active_columns) return 1'b0;
      magnitude = value;
      if (magnitude < 0) magnitude = -magnitude;
      if (magnitude > held_magnitude) begin
         held_peak = value;
         held_magnitude = magnitude;
      end
      if (samples_seen < COUNT_MAX) samples_seen++;
      if (samples_seen >= close_limit) begin
         closed.column_index = open_column[11:0];
         closed.peak_sample = held_peak;
         closed.last_column = (open_column + 1 == active_columns);
         pending_columns.push_back(closed);
         open_column++;
         close_limit += step_quot;
         step_frac += step_rem;
         if (active_columns != 0 && step_frac >= active_columns) begin
            step_frac -= active_columns;
            close_limit++;
         end
         close_limit &= COUNT_MAX;
         held_peak = '0;
         held_magnitude = 0;
      end
      return 1'b1;
   endfunction

   function automatic logic signed [15:0] pick_sample();
      int unsigned roll;
      logic signed [15:0] value;
      roll = $urandom_range(99);
      if (roll < 8) begin
         value = recent_sample;
      end else if (roll < 14) begin
         value = -recent_sample;
      end else if (roll < 24) begin
         case ($urandom_range(5))
            0: value = 16'sh8000;
            1: value = 16'sh7FFF;
            2: value = 16'sh8001;
            3: value = 16'sh0000;
            4: value = 16'shFFFF;
            default: value = 16'sh0001;
         endcase
      end else begin
         value = 16'($urandom);
      end
      recent_sample = value;
      return value;
   endfunction

   task automatic send_item(input logic op, input logic signed [15:0] value);
      while ($urandom_range(99) < push_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_op <= op;
      req_sample <= value;
      do @(posedge clock); while (req_full);
      if (advance_decimator(op, value)) counted_items++;
   endtask

   // drop the input side, drain every expected column, then let a restart finish
   task automatic settle_block();
      req_push <= 1'b0;
      while (pending_columns.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_registers(input longint unsigned total, input int unsigned columns);
      csr_we <= 1'b1;
      csr_index <= REG_TOTAL;
      csr_wdata <= total[39:0];
      @(posedge clock);
      cfg_total = total & COUNT_MAX;
      csr_index <= REG_COLUMNS;
      csr_wdata <= 40'(columns & 32'h1FFF);
      @(posedge clock);
      cfg_columns = columns & 32'h1FFF;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_waveform();
      longint unsigned total;
      int unsigned columns;
      int unsigned span;
      int unsigned effective;
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 88) begin
         if (roll < 62) begin
            columns = $urandom_range(1, 12);
            total = $urandom_range(0, 60);
         end else if (roll < 72) begin
            columns = $urandom_range(13, 8191);
            total = $urandom_range(0, 60);
         end else if (roll < 78) begin
            columns = 0;
            total = $urandom_range(0, 60);
         end else begin
            columns = $urandom_range(1, 4096);
            total = {$urandom, $urandom} & COUNT_MAX;
         end
         settle_block();
         load_registers(total, columns);
      end
      send_item(OP_RESTART, 16'($urandom));
      effective = (cfg_columns > MAX_COLS) ? MAX_COLS : 32'(cfg_columns);
      if (effective == 0) span = $urandom_range(1, 6);
      else if (cfg_total >= effective) begin
         span = (cfg_total > SPAN_CAP) ? SPAN_CAP : 32'(cfg_total) + $urandom_range(0, 4);
      end else span = effective + $urandom_range(0, 4);
      if (span > SPAN_CAP) span = SPAN_CAP;
      if ($urandom_range(99) < 12) span = $urandom_range(0, span);
      repeat (span) send_item(OP_SAMPLE, pick_sample());
   endtask

   task automatic test_power_on_column();
      push_idle_pct = 0;
      pop_stall_pct = 0;
      send_item(OP_SAMPLE, -16'sd5);
      send_item(OP_SAMPLE, 16'sd7);
   endtask

   task automatic test_peak_selection();
      settle_block();
      load_registers(6, 2);
      send_item(OP_RESTART, 16'sh7FFF);
      send_item(OP_SAMPLE, 16'sh8001);
      send_item(OP_SAMPLE, 16'sh7FFF);
      send_item(OP_SAMPLE, 16'sd3);
      send_item(OP_SAMPLE, -16'sd1);
      send_item(OP_SAMPLE, 16'sh8000);
      send_item(OP_SAMPLE, 16'sd1);
      send_item(OP_SAMPLE, 16'sd100);
      settle_block();
      load_registers(2, 2);
      send_item(OP_RESTART, 16'sh0000);
      send_item(OP_SAMPLE, 16'sd0);
      send_item(OP_SAMPLE, 16'sd0);
   endtask

   task automatic test_column_corners();
      settle_block();
      load_registers(5, 0);
      send_item(OP_RESTART, 16'sh8000);
      send_item(OP_SAMPLE, 16'sd9);
      settle_block();
      load_registers(3, 5);
      send_item(OP_RESTART, 16'sh5555);
      repeat (6) send_item(OP_SAMPLE, pick_sample());
      settle_block();
      load_registers(COUNT_MAX, 1);
      send_item(OP_RESTART, 16'shAAAA);
      send_item(OP_SAMPLE, 16'sh7FFF);
   endtask

   task automatic test_full_column_span();
      settle_block();
      load_registers(0, 8191);
      send_item(OP_RESTART, 16'sh0000);
      repeat (WIDE_SPAN) send_item(OP_SAMPLE, pick_sample());
   endtask

   task automatic test_random_waveforms(input int unsigned idle_pct, input int unsigned stall_pct);
      int start_items;
      push_idle_pct = idle_pct;
      pop_stall_pct = stall_pct;
      start_items = counted_items;
      while (counted_items - start_items < PHASE_ITEMS) run_waveform();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (pending_columns.size() == 0) begin
               fault_count++;
               if (fault_count <= 10) begin
                  $display("unexpected column: got index %0d peak %0d last %0b",
                     rsp_column_index, rsp_peak_sample, rsp_last_column);
               end
            end else begin
               want = pending_columns.pop_front();
               if (rsp_column_index !== want.column_index ||
                   rsp_peak_sample !== want.peak_sample ||
                   rsp_last_column !== want.last_column) begin
                  fault_count++;
                  if (fault_count <= 10) begin
                     $display("column mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                        want.column_index, want.peak_sample, want.last_column,
                        rsp_column_index, rsp_peak_sample, rsp_last_column);
                  end
               end
            end
         end
         rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_power_on_column();
      test_peak_selection();
      test_column_corners();
      test_full_column_span();
      test_random_waveforms(0, 0);
      test_random_waveforms(54, 0);
      test_random_waveforms(0, 54);
      test_random_waveforms(17, 17);
      settle_block();
      if (fault_count == 0 && pending_columns.size() == 0) begin
         $display("column_peak_decimator_top test passed");
      end else begin
         $display("column_peak_decimator_top test failed");
      end
      $finish;
   end

endmodule
